// File: rtl/core/sow_pkg.sv
`timescale 1ns / 1ps

package sow_pkg;

	// field and register widths
	localparam int IN_W = 32;
	localparam int CFG_W = 24;
	localparam int POW_W = 5;
	localparam int WEIGHT_W = 17;
	localparam int CFG_IDX_W = 2;

	// internal datapath widths
	localparam int ROOT_W = 28;
	localparam int A_W = 36;
	localparam int P_W = 46;
	localparam int X_W = 30;
	localparam int EXP_N_W = 6;
	localparam int TAYLOR_TERMS = 14;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_W-1:0] cfg_data_t;
	typedef logic [IN_W-1:0] strain_t;
	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef logic [ROOT_W-1:0] dist_t;
	typedef logic [P_W-1:0] pwr_t;
	typedef logic [X_W-1:0] xarg_t;

	// register indexes
	localparam cfg_idx_t REG_BETA = 2'd0;
	localparam cfg_idx_t REG_POWER = 2'd1;
	localparam cfg_idx_t REG_INV_WIDTH = 2'd2;

	// 1.0 in Q.24, power cap 2^21 in Q.24, exponent cap 32.0 in Q.24
	localparam dist_t ONE_Q24 = 28'h100_0000;
	localparam pwr_t PCAP = 46'h2000_0000_0000;
	localparam xarg_t XCAP = 30'h2000_0000;
	// ln 2 in Q.32
	localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

endpackage

// File: rtl/core/sow_sample_if.sv
`timescale 1ns / 1ps

interface sow_sample_if;
	logic valid;
	logic ready;
	sow_pkg::strain_t strain_sq;

	modport source (output valid, output strain_sq, input ready);
	modport sink (input valid, input strain_sq, output ready);
endinterface

// File: rtl/core/sow_result_if.sv
`timescale 1ns / 1ps

interface sow_result_if;
	logic valid;
	logic ready;
	sow_pkg::weight_t weight;

	modport source (output valid, output weight, input ready);
	modport sink (input valid, input weight, output ready);
endinterface

// File: rtl/core/sow_cfg_if.sv
`timescale 1ns / 1ps

interface sow_cfg_if;
	logic valid;
	logic ready;
	sow_pkg::cfg_idx_t index;
	sow_pkg::cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/sow_root.sv
`timescale 1ns / 1ps

// pipelined integer square root, one result bit per stage, then |sqrt(q) - 1|
module sow_root (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input sow_pkg::strain_t in_q,
	output logic out_valid,
	output sow_pkg::dist_t out_dist
);

	localparam int NSTG = sow_pkg::ROOT_W;
	localparam int VW = 2 * NSTG;

	logic vld_s [1:NSTG];
	logic [VW-1:0] rem_s [1:NSTG];
	logic [VW-1:0] res_s [1:NSTG];
	logic d_vld_s;
	sow_pkg::dist_t d_s;
	sow_pkg::dist_t root;

	for (genvar j = 0; j < NSTG; j++) begin : g_bit
		localparam logic [VW-1:0] BIT = VW'(1) << (VW - 2 - 2 * j);
		logic src_vld;
		logic [VW-1:0] src_rem;
		logic [VW-1:0] src_res;
		logic [VW-1:0] trial;
		logic take;

		if (j == 0) begin : g_first
			// q in Q8.24 shifted up by 24 so the root lands in Q.24
			assign src_vld = in_valid;
			assign src_rem = {in_q, 24'd0};
			assign src_res = '0;
		end else begin : g_next
			assign src_vld = vld_s[j];
			assign src_rem = rem_s[j];
			assign src_res = res_s[j];
		end

		assign trial = src_res + BIT;
		assign take = src_rem >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= take ? src_rem - trial : src_rem;
				res_s[j+1] <= take ? (src_res >> 1) + BIT : src_res >> 1;
			end
		end
	end

	assign root = res_s[NSTG][NSTG-1:0];

	// distance from one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_vld_s <= 1'b0;
		end else if (en) begin
			d_vld_s <= vld_s[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s <= (root >= sow_pkg::ONE_Q24) ? root - sow_pkg::ONE_Q24
				: sow_pkg::ONE_Q24 - root;
		end
	end

	assign out_valid = d_vld_s;
	assign out_dist = d_s;

endmodule

// File: rtl/core/sow_exp.sv
`timescale 1ns / 1ps

// weight = 1 - exp(-x): range reduction by ln 2, series up to rr^14/14!, final shift
module sow_exp #(
	parameter int OUT_FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input sow_pkg::xarg_t in_x,
	output logic out_valid,
	output sow_pkg::weight_t out_weight
);

	localparam int NB = sow_pkg::EXP_N_W;
	localparam int RW = sow_pkg::X_W + 8;
	localparam int NT = sow_pkg::TAYLOR_TERMS - 1;
	localparam logic [33:0] ONE32 = 34'(1) << 32;
	localparam logic [33:0] RND = 34'(1) << (31 - OUT_FRAC_BITS);
	localparam logic [33:0] OUT_ONE = 34'(1) << OUT_FRAC_BITS;

	// range reduction registers
	logic dv_vld_s [1:NB];
	logic [RW-1:0] dv_rem_s [1:NB];
	logic [NB-1:0] dv_n_s [1:NB];
	logic dv_sat_s [1:NB];

	// series start
	logic ti_vld_s;
	logic [31:0] ti_rr_s;
	logic [31:0] ti_term_s;
	logic [33:0] ti_pos_s;
	logic [33:0] ti_neg_s;
	logic [NB-1:0] ti_n_s;
	logic ti_sat_s;

	// series steps, three stages each
	logic ta_vld_s [0:NT-1];
	logic [63:0] ta_prod_s [0:NT-1];
	logic [31:0] ta_rr_s [0:NT-1];
	logic [33:0] ta_pos_s [0:NT-1];
	logic [33:0] ta_neg_s [0:NT-1];
	logic [NB-1:0] ta_n_s [0:NT-1];
	logic ta_sat_s [0:NT-1];

	logic tb_vld_s [0:NT-1];
	logic [31:0] tb_v_s [0:NT-1];
	logic [63:0] tb_vr_s [0:NT-1];
	logic [31:0] tb_rr_s [0:NT-1];
	logic [33:0] tb_pos_s [0:NT-1];
	logic [33:0] tb_neg_s [0:NT-1];
	logic [NB-1:0] tb_n_s [0:NT-1];
	logic tb_sat_s [0:NT-1];

	logic tl_vld_s [0:NT-1];
	logic [31:0] tl_term_s [0:NT-1];
	logic [31:0] tl_rr_s [0:NT-1];
	logic [33:0] tl_pos_s [0:NT-1];
	logic [33:0] tl_neg_s [0:NT-1];
	logic [NB-1:0] tl_n_s [0:NT-1];
	logic tl_sat_s [0:NT-1];

	// final scaling
	logic e_vld_s;
	logic [33:0] e_s;
	logic e_sat_s;
	logic [33:0] w_sum;
	logic [33:0] w_full;

	// n = X / ln2 by restoring division, one quotient bit per stage
	for (genvar j = 0; j < NB; j++) begin : g_div
		localparam logic [RW-1:0] DIVJ = RW'(sow_pkg::LN2_Q32) << (NB - 1 - j);
		logic src_vld;
		logic [RW-1:0] src_rem;
		logic [NB-1:0] src_n;
		logic src_sat;
		logic take;

		if (j == 0) begin : g_first
			assign src_vld = in_valid;
			assign src_rem = {in_x, 8'd0};
			assign src_n = '0;
			assign src_sat = in_x >= sow_pkg::XCAP;
		end else begin : g_next
			assign src_vld = dv_vld_s[j];
			assign src_rem = dv_rem_s[j];
			assign src_n = dv_n_s[j];
			assign src_sat = dv_sat_s[j];
		end

		assign take = src_rem >= DIVJ;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s[j+1] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[j+1] <= take ? src_rem - DIVJ : src_rem;
				dv_n_s[j+1] <= {src_n[NB-2:0], take};
				dv_sat_s[j+1] <= src_sat;
			end
		end
	end

	// first series term is rr itself
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ti_vld_s <= 1'b0;
		end else if (en) begin
			ti_vld_s <= dv_vld_s[NB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ti_rr_s <= dv_rem_s[NB][31:0];
			ti_term_s <= dv_rem_s[NB][31:0];
			ti_pos_s <= ONE32;
			ti_neg_s <= 34'(dv_rem_s[NB][31:0]);
			ti_n_s <= dv_n_s[NB];
			ti_sat_s <= dv_sat_s[NB];
		end
	end

	for (genvar s = 0; s < NT; s++) begin : g_term
		localparam int K = s + 2;
		localparam logic [31:0] RCP = 32'((64'd1 << 32) / K);
		logic src_vld;
		logic [31:0] src_term;
		logic [31:0] src_rr;
		logic [33:0] src_pos;
		logic [33:0] src_neg;
		logic [NB-1:0] src_n;
		logic src_sat;
		logic [31:0] qe;
		logic [35:0] chk;
		logic [31:0] term;

		if (s == 0) begin : g_first
			assign src_vld = ti_vld_s;
			assign src_term = ti_term_s;
			assign src_rr = ti_rr_s;
			assign src_pos = ti_pos_s;
			assign src_neg = ti_neg_s;
			assign src_n = ti_n_s;
			assign src_sat = ti_sat_s;
		end else begin : g_next
			assign src_vld = tl_vld_s[s-1];
			assign src_term = tl_term_s[s-1];
			assign src_rr = tl_rr_s[s-1];
			assign src_pos = tl_pos_s[s-1];
			assign src_neg = tl_neg_s[s-1];
			assign src_n = tl_n_s[s-1];
			assign src_sat = tl_sat_s[s-1];
		end

		// quotient estimate is low by at most one
		assign qe = tb_vr_s[s][63:32];
		assign chk = 36'(tb_v_s[s]) - 36'(qe) * 36'(K);
		assign term = (chk >= 36'(K)) ? qe + 32'd1 : qe;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ta_vld_s[s] <= 1'b0;
				tb_vld_s[s] <= 1'b0;
				tl_vld_s[s] <= 1'b0;
			end else if (en) begin
				ta_vld_s[s] <= src_vld;
				tb_vld_s[s] <= ta_vld_s[s];
				tl_vld_s[s] <= tb_vld_s[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				// term times rr
				ta_prod_s[s] <= 64'(src_term) * 64'(src_rr);
				ta_rr_s[s] <= src_rr;
				ta_pos_s[s] <= src_pos;
				ta_neg_s[s] <= src_neg;
				ta_n_s[s] <= src_n;
				ta_sat_s[s] <= src_sat;
				// divide by k through its reciprocal
				tb_v_s[s] <= ta_prod_s[s][63:32];
				tb_vr_s[s] <= 64'(ta_prod_s[s][63:32]) * 64'(RCP);
				tb_rr_s[s] <= ta_rr_s[s];
				tb_pos_s[s] <= ta_pos_s[s];
				tb_neg_s[s] <= ta_neg_s[s];
				tb_n_s[s] <= ta_n_s[s];
				tb_sat_s[s] <= ta_sat_s[s];
				// correct and accumulate
				tl_term_s[s] <= term;
				tl_rr_s[s] <= tb_rr_s[s];
				tl_n_s[s] <= tb_n_s[s];
				tl_sat_s[s] <= tb_sat_s[s];
				if ((K % 2) == 0) begin
					tl_pos_s[s] <= tb_pos_s[s] + 34'(term);
					tl_neg_s[s] <= tb_neg_s[s];
				end else begin
					tl_pos_s[s] <= tb_pos_s[s];
					tl_neg_s[s] <= tb_neg_s[s] + 34'(term);
				end
			end
		end
	end

	// exp(-x) = series >> n
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_vld_s <= 1'b0;
		end else if (en) begin
			e_vld_s <= tl_vld_s[NT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s <= (tl_pos_s[NT-1] - tl_neg_s[NT-1]) >> tl_n_s[NT-1];
			e_sat_s <= tl_sat_s[NT-1];
		end
	end

	// round 1 - e to the output format
	assign w_sum = ONE32 - e_s + RND;
	assign w_full = w_sum >> (32 - OUT_FRAC_BITS);

	assign out_valid = e_vld_s;
	assign out_weight = e_sat_s ? OUT_ONE[sow_pkg::WEIGHT_W-1:0]
		: w_full[sow_pkg::WEIGHT_W-1:0];

endmodule

// File: rtl/core/strain_omega_weight.sv
`timescale 1ns / 1ps

// channel   dir   payload                     transfer when
// sample    in    strain_sq  (Q8.24)          sample.valid & sample.ready
// result    out   weight     (Q1.16)          result.valid & result.ready
// cfg       in    index, data                 cfg.valid & cfg.ready (always ready)
//
// one item per cycle while the skid is empty; a sample passes the root stages, the power
// multiply chain, the series and the output register on its way to result valid.
// arst_n clears every valid bit and loads the register defaults.
// a stalled result parks in a one-entry skid; the pipeline then freezes as a whole.
module strain_omega_weight #(
	parameter int MAX_POWER = 16,
	parameter int OUT_FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	sow_sample_if.sink sample,
	sow_result_if.source result,
	sow_cfg_if.sink cfg
);

	localparam int PW = sow_pkg::P_W;
	localparam int HW = PW / 2;
	localparam int AH = sow_pkg::A_W / 2;

	// configuration registers
	sow_pkg::cfg_data_t beta_q;
	logic [sow_pkg::POW_W-1:0] power_q;
	sow_pkg::cfg_data_t inv_width_q;

	logic en;
	logic rt_valid;
	sow_pkg::dist_t rt_dist;

	logic a_vld_s1;
	logic [sow_pkg::A_W-1:0] a_s1;
	logic sq_vld_s2;
	logic [2*AH-1:0] sq_hh_s2;
	logic [2*AH-1:0] sq_hl_s2;
	logic [2*AH-1:0] sq_ll_s2;
	logic t_vld_s3;
	sow_pkg::pwr_t t_s3;
	logic [2*sow_pkg::A_W-1:0] sq_full;
	logic [2*sow_pkg::A_W-25:0] sq_sh;

	// power chain, two stages per multiply
	logic pa_vld_s [0:MAX_POWER-1];
	logic pa_act_s [0:MAX_POWER-1];
	sow_pkg::pwr_t pa_p_s [0:MAX_POWER-1];
	sow_pkg::pwr_t pa_t_s [0:MAX_POWER-1];
	logic [2*HW-1:0] pa_hh_s [0:MAX_POWER-1];
	logic [2*HW-1:0] pa_hl_s [0:MAX_POWER-1];
	logic [2*HW-1:0] pa_lh_s [0:MAX_POWER-1];
	logic [2*HW-1:0] pa_ll_s [0:MAX_POWER-1];
	logic pw_vld_s [1:MAX_POWER];
	sow_pkg::pwr_t pw_p_s [1:MAX_POWER];
	sow_pkg::pwr_t pw_t_s [1:MAX_POWER];

	logic bx_vld_s4;
	logic [sow_pkg::CFG_W+HW-1:0] bx_hi_s4;
	logic [sow_pkg::CFG_W+HW-1:0] bx_lo_s4;
	logic x_vld_s5;
	sow_pkg::xarg_t x_s5;
	logic [sow_pkg::CFG_W+PW-1:0] bx_full;
	logic [sow_pkg::CFG_W+PW-17:0] bx_sh;

	logic ex_valid;
	sow_pkg::weight_t ex_weight;

	logic out_valid_q;
	sow_pkg::weight_t out_weight_q;
	logic skid_valid_q;
	sow_pkg::weight_t skid_weight_q;
	logic out_free;

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= 24'd65536;
			power_q <= 5'd1;
			inv_width_q <= 24'd65536;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				sow_pkg::REG_BETA: beta_q <= cfg.data;
				sow_pkg::REG_POWER: power_q <= cfg.data[sow_pkg::POW_W-1:0];
				sow_pkg::REG_INV_WIDTH: inv_width_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// whole pipeline moves unless the skid holds a result
	assign en = ~skid_valid_q;
	assign sample.ready = en;

	sow_root u_root (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(sample.valid),
		.in_q(sample.strain_sq),
		.out_valid(rt_valid),
		.out_dist(rt_dist)
	);

	// |s| = d * inv_width, then s^2 via partial products and saturation
	assign sq_full = ((2*sow_pkg::A_W)'(sq_hh_s2) << (2 * AH))
		+ ((2*sow_pkg::A_W)'(sq_hl_s2) << (AH + 1))
		+ (2*sow_pkg::A_W)'(sq_ll_s2);
	assign sq_sh = sq_full[2*sow_pkg::A_W-1:24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_vld_s1 <= 1'b0;
			sq_vld_s2 <= 1'b0;
			t_vld_s3 <= 1'b0;
		end else if (en) begin
			a_vld_s1 <= rt_valid;
			sq_vld_s2 <= a_vld_s1;
			t_vld_s3 <= sq_vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= sow_pkg::A_W'((52'(rt_dist) * 52'(inv_width_q)) >> 16);
			sq_hh_s2 <= a_s1[2*AH-1:AH] * a_s1[2*AH-1:AH];
			sq_hl_s2 <= a_s1[2*AH-1:AH] * a_s1[AH-1:0];
			sq_ll_s2 <= a_s1[AH-1:0] * a_s1[AH-1:0];
			t_s3 <= (sq_sh > (2*sow_pkg::A_W-24)'(sow_pkg::PCAP)) ? sow_pkg::PCAP
				: sq_sh[PW-1:0];
		end
	end

	// p = (s^2)^m, one multiply per step, steps past m pass p through
	for (genvar i = 0; i < MAX_POWER; i++) begin : g_pow
		logic src_vld;
		sow_pkg::pwr_t src_p;
		sow_pkg::pwr_t src_t;
		logic [2*PW:0] full;
		logic [2*PW-24:0] sh;
		sow_pkg::pwr_t prod;

		if (i == 0) begin : g_first
			assign src_vld = t_vld_s3;
			assign src_p = PW'(sow_pkg::ONE_Q24);
			assign src_t = t_s3;
		end else begin : g_next
			assign src_vld = pw_vld_s[i];
			assign src_p = pw_p_s[i];
			assign src_t = pw_t_s[i];
		end

		assign full = ((2*PW+1)'(pa_hh_s[i]) << (2 * HW))
			+ ((2*PW+1)'(pa_hl_s[i]) << HW)
			+ ((2*PW+1)'(pa_lh_s[i]) << HW)
			+ (2*PW+1)'(pa_ll_s[i]);
		assign sh = full[2*PW:24];
		assign prod = (sh > (2*PW-23)'(sow_pkg::PCAP)) ? sow_pkg::PCAP : sh[PW-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pa_vld_s[i] <= 1'b0;
				pw_vld_s[i+1] <= 1'b0;
			end else if (en) begin
				pa_vld_s[i] <= src_vld;
				pw_vld_s[i+1] <= pa_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pa_act_s[i] <= int'(power_q) > i;
				pa_p_s[i] <= src_p;
				pa_t_s[i] <= src_t;
				pa_hh_s[i] <= src_p[PW-1:HW] * src_t[PW-1:HW];
				pa_hl_s[i] <= src_p[PW-1:HW] * src_t[HW-1:0];
				pa_lh_s[i] <= src_p[HW-1:0] * src_t[PW-1:HW];
				pa_ll_s[i] <= src_p[HW-1:0] * src_t[HW-1:0];
				pw_p_s[i+1] <= pa_act_s[i] ? prod : pa_p_s[i];
				pw_t_s[i+1] <= pa_t_s[i];
			end
		end
	end

	// x = beta * p, saturated at 32.0
	assign bx_full = ((sow_pkg::CFG_W+PW)'(bx_hi_s4) << HW)
		+ (sow_pkg::CFG_W+PW)'(bx_lo_s4);
	assign bx_sh = bx_full[sow_pkg::CFG_W+PW-1:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bx_vld_s4 <= 1'b0;
			x_vld_s5 <= 1'b0;
		end else if (en) begin
			bx_vld_s4 <= pw_vld_s[MAX_POWER];
			x_vld_s5 <= bx_vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bx_hi_s4 <= beta_q * pw_p_s[MAX_POWER][PW-1:HW];
			bx_lo_s4 <= beta_q * pw_p_s[MAX_POWER][HW-1:0];
			x_s5 <= (bx_sh > (sow_pkg::CFG_W+PW-16)'(sow_pkg::XCAP)) ? sow_pkg::XCAP
				: bx_sh[sow_pkg::X_W-1:0];
		end
	end

	sow_exp #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_exp (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(x_vld_s5),
		.in_x(x_s5),
		.out_valid(ex_valid),
		.out_weight(ex_weight)
	);

	// output register with one-entry skid
	assign out_free = ~out_valid_q | result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= ex_valid;
			end
		end else if (en && ex_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_weight_q <= skid_valid_q ? skid_weight_q : ex_weight;
		end else if (en && ex_valid) begin
			skid_weight_q <= ex_weight;
		end
	end

	assign result.valid = out_valid_q;
	assign result.weight = out_weight_q;

	// skid only ever holds a result behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid full with empty output register");

	// skid fills only when the output was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(result.valid && !result.ready))
		else $error("skid filled without output stall");

	// pipeline frozen while skid is full
	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !result.ready |=> $stable(x_vld_s5) && $stable(t_vld_s3))
		else $error("pipeline moved while skid full");

endmodule
